// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define UPC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define UPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg
// types, constants and character helpers for the url percent codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upc_pkg;

  // command queue depth, must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // decode escape progress
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_FIRST = 2'd2
  } esc_phase_t;

  // work handed from front to back
  typedef enum logic {
    CMD_PLAIN  = 1'b0,
    CMD_ESCAPE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic       direction;
    esc_phase_t phase;
  } front_status_t;

  // letters, digits and - _ . , pass through the encoder
  function automatic logic is_plain(input logic [7:0] b);
    logic r;
    r = ((b >= 8'h41) && (b <= 8'h5A)) ||
        ((b >= 8'h61) && (b <= 8'h7A)) ||
        ((b >= 8'h30) && (b <= 8'h39)) ||
        (b == 8'h2D) || (b == 8'h5F) || (b == 8'h2E) || (b == 8'h2C);
    return r;
  endfunction

  // bit 4 set when b is not a hex digit, else bits 3..0 hold the value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    logic [4:0] r;
    r = 5'h10;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      t = b - 8'h30;
      r = {1'b0, t[3:0]};
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      t = b - 8'h37;
      r = {1'b0, t[3:0]};
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      t = b - 8'h57;
      r = {1'b0, t[3:0]};
    end
    return r;
  endfunction

  // upper-case hex character for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'b0, v};
    end else begin
      r = 8'h37 + {4'b0, v};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/upc_front.sv =====
// ----------------------------------------------------------------------------
// upc_front
// accepts input bytes, tracks decode escapes and issues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upc_front import upc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          q_full,
  output logic               push,
  output cmd_t               push_cmd,
  output front_status_t      status
);

  logic       direction_r, direction_nxt;
  esc_phase_t phase_r, phase_nxt;
  logic [4:0] first_digit_r, first_digit_nxt;
  logic       accept;
  logic [4:0] hv;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hv       = hex_value(in_byte);

  assign status.direction = direction_r;
  assign status.phase     = phase_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= DIR_ENCODE;
      phase_r       <= PH_IDLE;
      first_digit_r <= '0;
    end else begin
      direction_r   <= direction_nxt;
      phase_r       <= phase_nxt;
      first_digit_r <= first_digit_nxt;
    end
  end

  // classify byte, advance escape state
  always_comb begin
    direction_nxt   = direction_r;
    phase_nxt       = phase_r;
    first_digit_nxt = first_digit_r;
    push            = 1'b0;
    push_cmd.kind   = CMD_PLAIN;
    push_cmd.data   = in_byte;
    if (cfg_wr_en) begin
      // a direction write drops any pending escape
      direction_nxt   = cfg_wr_data;
      phase_nxt       = PH_IDLE;
      first_digit_nxt = '0;
    end else if (accept) begin
      if (direction_r == DIR_ENCODE) begin
        push          = 1'b1;
        push_cmd.kind = is_plain(in_byte) ? CMD_PLAIN : CMD_ESCAPE;
      end else begin
        case (phase_r)
          PH_PCT: begin
            first_digit_nxt = hv[4] ? 5'h00 : {1'b1, hv[3:0]};
            phase_nxt       = PH_FIRST;
          end
          PH_FIRST: begin
            push = 1'b1;
            if (!first_digit_r[4]) begin
              push_cmd.data = 8'h00;
            end else if (hv[4]) begin
              push_cmd.data = {4'b0, first_digit_r[3:0]};
            end else begin
              push_cmd.data = {first_digit_r[3:0], hv[3:0]};
            end
            phase_nxt       = PH_IDLE;
            first_digit_nxt = '0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (in_byte == CH_PERCENT) begin
              phase_nxt       = PH_PCT;
              first_digit_nxt = '0;
            end else if (in_byte == CH_PLUS) begin
              push          = 1'b1;
              push_cmd.data = CH_SPACE;
            end else begin
              push = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/upc_queue.sv =====
// ----------------------------------------------------------------------------
// upc_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upc_queue import upc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head,
  output q_status_t  status
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign status.count = count_r;
  assign head         = slot_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/upc_back.sv =====
// ----------------------------------------------------------------------------
// upc_back
// expands commands into output bytes, one byte per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upc_back import upc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run
);

  localparam logic [1:0] STEP_PCT = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_LO  = 2'd2;

  logic       busy_r, busy_nxt;
  logic [1:0] step_r, step_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic       fire;

  assign out_valid = busy_r;
  assign fire      = busy_r && !out_stall;

  // output byte selection from the held command
  always_comb begin
    case (step_r)
      STEP_PCT: out_byte = (cmd_r.kind == CMD_ESCAPE) ? CH_PERCENT : cmd_r.data;
      STEP_HI:  out_byte = hex_char(cmd_r.data[7:4]);
      STEP_LO:  out_byte = hex_char(cmd_r.data[3:0]);
      default:  out_byte = cmd_r.data;
    endcase
    out_last_of_run = (cmd_r.kind == CMD_PLAIN) || (step_r == STEP_LO);
  end

  // take the next command when idle or finishing the current one
  always_comb begin
    pop      = (!busy_r || (fire && out_last_of_run)) && !q_empty;
    busy_nxt = busy_r;
    step_nxt = step_r;
    cmd_nxt  = cmd_r;
    if (pop) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_PCT;
      cmd_nxt  = head;
    end else if (fire) begin
      if (out_last_of_run) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_PCT;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/url_percent_codec.sv =====
// an input byte is held in a queue slot, then in the back end's command register, before it leaves
// throughput: one output byte per cycle from the back end's single output port while out_stall is low;
//   a plain or decoded byte gives one output byte, an encoded escape gives three output bytes
// a two-entry command queue lets input continue while output is stalled
// reset: synchronous, active low; direction is encode, no escape pending, queue empty
// ----------------------------------------------------------------------------
// url_percent_codec
// byte stream url percent encoder and decoder with a direction register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module url_percent_codec import upc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);

  logic          push, pop;
  cmd_t          push_cmd, head;
  q_status_t     q_status;
  front_status_t f_status;

  // accept and classify
  upc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .q_full      (q_status.full),
    .push        (push),
    .push_cmd    (push_cmd),
    .status      (f_status)
  );

  // command queue
  upc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // byte expansion and output
  upc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_status.empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // queue occupancy stays within its depth
  `UPC_ASSERT_ALWAYS(a_q_bound, q_status.count <= QCNT_W'(QUEUE_DEPTH), "queue over depth")
  // only the encoder produces multi-byte runs
  `UPC_ASSERT_IMPL(a_multi_enc, out_valid && !out_last_of_run, f_status.direction == DIR_ENCODE, "multi-byte run while decoding")
  // a direction write drops any pending escape
  `UPC_ASSERT_NEXT(a_cfg_clear, cfg_wr_en, f_status.phase == PH_IDLE, "escape pending after direction write")

endmodule

`default_nettype wire

// ===== bench/url_percent_codec_tb.sv =====
// ----------------------------------------------------------------------------
// url_percent_codec_tb
// self-checking bench for the url percent codec: a queue-fed driver offers
// bytes with random gaps, a clocked monitor predicts the converted stream at
// each accepted input transfer and checks every output transfer in order,
// across encode and decode settings, long output stalls and drained pauses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module url_percent_codec_tb import upc_pkg::*;;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 8;
  localparam int LONG_HOLD    = 60;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 38;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  // bytes waiting to be offered and converted bytes still owed by the block
  logic [7:0] pending_bytes[$];
  out_item_t  expected_out[$];

  // mirror of the block's register and escape state
  logic       direction = DIR_ENCODE;
  esc_phase_t esc_phase = PH_IDLE;
  logic [4:0] first_digit = 5'h00;

  int unsigned pushed_n = 0;
  int unsigned accepted_n = 0;
  int unsigned fail_count = 0;
  logic        in_taken = 1'b0;
  logic        quiet = 1'b0;
  logic        long_hold_req = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;

  url_percent_codec uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // letters, digits and the four marks survive encoding
  function automatic logic is_url_safe(input logic [7:0] b);
    if (b >= "a" && b <= "z") return 1'b1;
    if (b >= "A" && b <= "Z") return 1'b1;
    if (b >= "0" && b <= "9") return 1'b1;
    return (b == "-") || (b == "_") || (b == ".") || (b == ",");
  endfunction

  // bit 4 flags a hex digit, bits 3..0 its value; zero when not hex
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= "0" && b <= "9") begin
      d = b - "0";
    end else if (b >= "A" && b <= "F") begin
      d = b - "A" + 8'd10;
    end else if (b >= "a" && b <= "f") begin
      d = b - "a" + 8'd10;
    end else begin
      return 5'h00;
    end
    return {1'b1, d[3:0]};
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + {4'h0, n};
    return "A" + {4'h0, n} - 8'd10;
  endfunction

  // hex digit character of random value and random case
  function automatic logic [7:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if (n >= 4'd10 && $urandom_range(0, 1) == 1) return "a" + {4'h0, n} - 8'd10;
    return nibble_char(n);
  endfunction

  task automatic expect_byte(input logic [7:0] b, input logic last);
    out_item_t it;
    it.data = b;
    it.last = last;
    expected_out.push_back(it);
  endtask

  // converted bytes caused by one accepted input byte
  task automatic predict_converted(input logic [7:0] b);
    logic [4:0] h;
    logic [7:0] v;
    h = hex_nibble(b);
    if (direction == DIR_ENCODE) begin
      if (is_url_safe(b)) begin
        expect_byte(b, 1'b1);
      end else begin
        expect_byte(CH_PERCENT, 1'b0);
        expect_byte(nibble_char(b[7:4]), 1'b0);
        expect_byte(nibble_char(b[3:0]), 1'b1);
      end
    end else begin
      case (esc_phase)
        PH_PCT: begin
          first_digit = h;
          esc_phase = PH_FIRST;
        end
        PH_FIRST: begin
          v = 8'h00;
          if (first_digit[4]) begin
            v = {4'h0, first_digit[3:0]};
            if (h[4]) v = {first_digit[3:0], h[3:0]};
          end
          expect_byte(v, 1'b1);
          esc_phase = PH_IDLE;
          first_digit = 5'h00;
        end
        default: begin
          esc_phase = PH_IDLE;
          if (b == CH_PERCENT) begin
            esc_phase = PH_PCT;
            first_digit = 5'h00;
          end else if (b == CH_PLUS) begin
            expect_byte(CH_SPACE, 1'b1);
          end else begin
            expect_byte(b, 1'b1);
          end
        end
      endcase
    end
  endtask

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t %s", $realtime, msg);
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    pushed_n++;
  endtask

  // wait until every byte is taken and every converted byte has come out
  task automatic wait_drained();
    while (accepted_n != pushed_n || expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_direction(input logic d);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    direction = d;
    esc_phase = PH_IDLE;
    first_digit = 5'h00;
  endtask

  task automatic add_encode_traffic(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 255)));
      else push_byte(rand_hex_char() ^ ($urandom_range(0, 1) ? 8'h00 : 8'h20));
    end
  endtask

  // mostly well-formed escapes with random content, some noise and broken ones
  task automatic add_decode_traffic(input int n);
    int k;
    int r;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 9);
      if (r <= 3) begin
        push_byte(CH_PERCENT);
        push_byte(rand_hex_char());
        push_byte(rand_hex_char());
        k += 3;
      end else if (r == 4) begin
        push_byte(CH_PERCENT);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
        k += 3;
      end else if (r == 5) begin
        push_byte(CH_PLUS);
        k += 1;
      end else if (r <= 8) begin
        push_byte(8'($urandom_range(0, 255)));
        k += 1;
      end else begin
        push_byte(CH_PERCENT);
        push_byte(rand_hex_char());
        k += 2;
      end
    end
  endtask

  // input driver: holds a stalled transfer, otherwise gaps or next byte
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      gap_left = $urandom_range(0, 3);
      in_valid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      in_valid <= 1'b1;
      in_byte <= pending_bytes.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output stall: long hold on request, short random bursts otherwise
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_converted(in_byte);
        accepted_n++;
      end
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          flag_error($sformatf("unexpected output byte %02h last %0b",
                               out_byte, out_last_of_run));
        end else begin
          want = expected_out.pop_front();
          if (out_byte !== want.data)
            flag_error($sformatf("out_byte expected %02h got %02h", want.data, out_byte));
          if (out_last_of_run !== want.last)
            flag_error($sformatf("out_last_of_run expected %0b got %0b (byte %02h)",
                                 want.last, out_last_of_run, want.data));
        end
      end
    end
  end

  // run limit
  initial begin
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("url_percent_codec_tb: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    int p;
    logic d;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // encode corners: byte extremes, every safe class, escaped marks
    write_direction(DIR_ENCODE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte("A");
    push_byte("z");
    push_byte("9");
    push_byte("-");
    push_byte("_");
    push_byte(".");
    push_byte(",");
    push_byte(CH_PERCENT);
    wait_drained();

    // decode corners: plus, plain, both-hex, first-only, non-hex, escape chars
    write_direction(DIR_DECODE);
    push_byte(CH_PLUS);
    push_byte("q");
    push_byte(CH_PERCENT); push_byte("4"); push_byte("1");
    push_byte(CH_PERCENT); push_byte("f"); push_byte("F");
    push_byte(CH_PERCENT); push_byte("a"); push_byte("g");
    push_byte(CH_PERCENT); push_byte("g"); push_byte("1");
    push_byte(CH_PERCENT); push_byte(CH_PERCENT); push_byte(CH_PLUS);
    // pending escape is dropped by a register write
    push_byte(CH_PERCENT); push_byte("4");
    wait_drained();
    write_direction(DIR_DECODE);
    push_byte("4"); push_byte("1");
    wait_drained();

    // random phases alternating direction
    for (p = 0; p < RAND_PHASES; p++) begin
      d = (p % 2 == 0) ? DIR_DECODE : DIR_ENCODE;
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      write_direction(d);
      if (p == 2) long_hold_req = 1'b1;
      if (d == DIR_ENCODE) add_encode_traffic(PHASE_ITEMS / 2);
      else add_decode_traffic(PHASE_ITEMS / 2);
      // sender pause until the block is empty
      if (p == 4) wait_drained();
      if (d == DIR_ENCODE) add_encode_traffic(PHASE_ITEMS / 2);
      else add_decode_traffic(PHASE_ITEMS / 2);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("url_percent_codec_tb: PASS");
    end else begin
      $display("url_percent_codec_tb: FAIL");
    end
    $finish;
  end

endmodule
